>>> design/rv32sde_pkg.sv
// Package for the RV32 subset decode/execute unit: payload structs, opcodes,
// controller/datapath command and status types. No dependencies.
package rv32sde_pkg;

   localparam int unsigned NUM_REGS_DEFAULT = 32;
   localparam logic [31:0] SP_RESET_VALUE   = 32'd4000;
   localparam logic [4:0]  SP_REG_INDEX     = 5'd2;

   // Opcodes
   localparam logic [6:0] OP_LA     = 7'd0;
   localparam logic [6:0] OP_LOAD   = 7'd3;
   localparam logic [6:0] OP_HALT   = 7'd17;
   localparam logic [6:0] OP_IMM    = 7'd19;
   localparam logic [6:0] OP_STORE  = 7'd35;
   localparam logic [6:0] OP_REG    = 7'd51;
   localparam logic [6:0] OP_REGW   = 7'd59;
   localparam logic [6:0] OP_LUI    = 7'd55;
   localparam logic [6:0] OP_BRANCH = 7'd99;
   localparam logic [6:0] OP_JALR   = 7'd103;
   localparam logic [6:0] OP_JAL    = 7'd111;

   localparam logic [6:0] F7_BASE = 7'd0;
   localparam logic [6:0] F7_MULDIV = 7'd1;
   localparam logic [6:0] F7_ALT  = 7'd32;

   // Memory request codes
   localparam logic [2:0] MEM_NONE = 3'd0;
   localparam logic [2:0] MEM_LB   = 3'd1;
   localparam logic [2:0] MEM_LW   = 3'd2;
   localparam logic [2:0] MEM_SB   = 3'd3;
   localparam logic [2:0] MEM_SW   = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [31:0] instr_word;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0]        next_pc;
      logic [2:0]         mem_op;
      logic [31:0]        mem_addr;
      logic [31:0]        store_value;
      logic [4:0]         dest_reg;
      logic signed [31:0] write_value;
      logic               write_enable;
      logic               halted;
      logic               unknown_op;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic clear_step;   // reset-time register file clearing
      logic capture;      // latch request, launch operand read
      logic execute;      // decode and execute from read operands
      logic md_step;      // one mul/div iteration
      logic commit;       // write back, update pc and result register
   } dp_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic md_needed;
      logic md_done;
   } dp_sts_type;

endpackage

>>> design/rv32sde_datapath.sv
// Datapath of the RV32 subset unit: register file memory, decoder, ALU,
// iterative multiply/divide unit, pc and result register. Uses rv32sde_pkg.
module rv32sde_datapath #(
   parameter int unsigned NUM_REGS = rv32sde_pkg::NUM_REGS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rv32sde_pkg::req_type     req_data,
   input  rv32sde_pkg::dp_cmd_type  cmd,
   output rv32sde_pkg::dp_sts_type  sts,
   output rv32sde_pkg::rsp_type     rsp_data
);
   localparam int unsigned AW = $clog2(NUM_REGS);

   // Register file: written one address, read two, read data registered
   logic [31:0] regs_mem [NUM_REGS];
   logic [31:0] rd_a_ff, rd_b_ff;

   logic [AW:0]   clr_cnt_ff, clr_cnt_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   rv32sde_pkg::req_type req_ff;
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [4:0]  pend_ff, pend_in;
   rv32sde_pkg::rsp_type rsp_ff, rsp_in;

   // Execute-stage registers
   rv32sde_pkg::rsp_type exe_ff, exe_in;
   logic        exe_md_ff, exe_is_div_ff;

   // Mul/div unit state
   logic [31:0] md_acc_ff, md_acc_in;   // product or remainder
   logic [31:0] md_q_ff, md_q_in;       // multiplier bits or quotient
   logic [31:0] md_b_ff, md_b_in;       // multiplicand or divisor magnitude
   logic [5:0]  md_cnt_ff, md_cnt_in;
   logic        md_neg_ff, md_neg_in;
   logic        md_fix_ff, md_fix_in;   // special-case result held in md_q
   logic        md_div_ff;

   // Clear sweep counter
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clear_step && !clr_cnt_ff[AW]) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
   end
   assign sts.clear_done = clr_cnt_ff[AW];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Register file write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_mem[wr_addr] <= wr_data;
      end
      if (cmd.capture) begin
         rd_a_ff <= regs_mem[req_data.instr_word[15+:AW]];
         rd_b_ff <= regs_mem[req_data.instr_word[20+:AW]];
      end
   end

   // Decode and execute
   logic [31:0] ir, a, b, imm_i, imm_s, off_b, off_j, alu_b, alu_res;
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  rd, sh;
   logic        alu_ok, take, wr, is_reg, lt_s, lt_u, md_req, md_div;

   always_comb begin
      ir    = req_ff.instr_word;
      op    = ir[6:0];
      rd    = ir[11:7];
      f3    = ir[14:12];
      f7    = ir[31:25];
      a     = rd_a_ff;
      b     = rd_b_ff;
      imm_i = {{20{ir[31]}}, ir[31:20]};
      imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
      off_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
      off_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
      is_reg = (op == rv32sde_pkg::OP_REG) || (op == rv32sde_pkg::OP_REGW);
      alu_b = is_reg ? b : imm_i;
      sh    = alu_b[4:0];
      lt_s  = $signed(a) < $signed(alu_b);
      lt_u  = a < alu_b;
      alu_ok  = 1'b1;
      alu_res = '0;
      md_req  = 1'b0;
      md_div  = 1'b0;
      if (is_reg && f7 == rv32sde_pkg::F7_MULDIV) begin
         md_req = (f3 == 3'd0) || (f3 == 3'd4);
         md_div = (f3 == 3'd4);
         alu_ok = md_req;
      end else if (is_reg && f7 == rv32sde_pkg::F7_ALT) begin
         if (f3 == 3'd0) begin
            alu_res = a - b;
         end else if (f3 == 3'd5) begin
            alu_res = 32'($signed(a) >>> sh);
         end else begin
            alu_ok = 1'b0;
         end
      end else if (is_reg && f7 != rv32sde_pkg::F7_BASE) begin
         alu_ok = 1'b0;
      end else begin
         unique case (f3)
            3'd0: alu_res = a + alu_b;
            3'd1: alu_res = a << sh;
            3'd2: alu_res = {31'd0, lt_s};
            3'd3: alu_res = {31'd0, lt_u};
            3'd4: alu_res = a ^ alu_b;
            3'd5: begin
               if (f7 == rv32sde_pkg::F7_BASE) begin
                  alu_res = a >> sh;
               end else if (f7 == rv32sde_pkg::F7_ALT) begin
                  alu_res = 32'($signed(a) >>> sh);
               end else begin
                  alu_ok = 1'b0;
               end
            end
            3'd6: alu_res = a | alu_b;
            default: alu_res = a & alu_b;
         endcase
      end

      unique case (f3)
         3'd0: take = (a == b);
         3'd1: take = (a != b);
         3'd4: take = $signed(a) < $signed(b);
         3'd5: take = !($signed(a) < $signed(b));
         3'd6: take = a < b;
         3'd7: take = a >= b;
         default: take = 1'b0;
      endcase

      exe_in = '0;
      exe_in.next_pc = pc_ff + 32'd4;
      wr = 1'b0;
      pend_in = pend_ff;
      halt_in = halt_ff;
      if (req_ff.mode) begin
         rd = pend_ff;
         exe_in.write_value = req_ff.load_data;
         wr = 1'b1;
         pend_in = '0;
         exe_in.next_pc = pc_ff;
      end else if (halt_ff) begin
         exe_in.next_pc = pc_ff;
      end else begin
         unique case (op)
            rv32sde_pkg::OP_HALT: begin
               halt_in = 1'b1;
               exe_in.next_pc = pc_ff;
            end
            rv32sde_pkg::OP_REG, rv32sde_pkg::OP_REGW, rv32sde_pkg::OP_IMM: begin
               exe_in.write_value = alu_res;
               wr = alu_ok;
               exe_in.unknown_op = !alu_ok;
            end
            rv32sde_pkg::OP_LOAD: begin
               exe_in.mem_op = (f3 == 3'd0) ? rv32sde_pkg::MEM_LB : rv32sde_pkg::MEM_LW;
               exe_in.mem_addr = a + imm_i;
               pend_in = rd;
            end
            rv32sde_pkg::OP_STORE: begin
               exe_in.mem_op = (f3 == 3'd0) ? rv32sde_pkg::MEM_SB : rv32sde_pkg::MEM_SW;
               exe_in.mem_addr = a + imm_s;
               exe_in.store_value = b;
            end
            rv32sde_pkg::OP_BRANCH: begin
               exe_in.unknown_op = (f3 == 3'd2) || (f3 == 3'd3);
               if (take) begin
                  exe_in.next_pc = pc_ff + off_b;
               end
            end
            rv32sde_pkg::OP_JALR: begin
               exe_in.next_pc = (a + imm_i) & ~32'd1;
               exe_in.write_value = pc_ff + 32'd4;
               wr = 1'b1;
            end
            rv32sde_pkg::OP_JAL: begin
               exe_in.next_pc = pc_ff + off_j;
               exe_in.write_value = pc_ff + 32'd4;
               wr = 1'b1;
            end
            rv32sde_pkg::OP_LUI: begin
               exe_in.write_value = {ir[31:12], 12'd0};
               wr = 1'b1;
            end
            rv32sde_pkg::OP_LA: begin
               exe_in.write_value = {{12{ir[31]}}, ir[31:12]};
               wr = 1'b1;
            end
            default: exe_in.unknown_op = 1'b1;
         endcase
      end
      exe_in.dest_reg = rd;
      exe_in.write_enable = wr;
      exe_in.halted = halt_in;
   end

   assign sts.md_needed = exe_md_ff;

   // Mul/div: one bit per cycle, 32 iterations
   logic [31:0] abs_a, abs_b;
   logic [32:0] trial;
   always_comb begin
      abs_a = a[31] ? (32'd0 - a) : a;
      abs_b = b[31] ? (32'd0 - b) : b;
      trial = {md_acc_ff, md_q_ff[31]} - {1'b0, md_b_ff};
      md_acc_in = md_acc_ff;
      md_q_in   = md_q_ff;
      md_b_in   = md_b_ff;
      md_cnt_in = md_cnt_ff;
      md_neg_in = md_neg_ff;
      md_fix_in = md_fix_ff;
      if (cmd.execute) begin
         md_cnt_in = '0;
         md_fix_in = 1'b0;
         md_acc_in = '0;
         if (md_div) begin
            md_q_in   = abs_a;
            md_b_in   = abs_b;
            md_neg_in = a[31] ^ b[31];
            if (b == 32'd0) begin
               md_fix_in = 1'b1;
               md_q_in   = '1;
            end else if (a == 32'h8000_0000 && b == '1) begin
               md_fix_in = 1'b1;
               md_q_in   = 32'h8000_0000;
            end
         end else begin
            md_q_in   = b;
            md_b_in   = a;
            md_neg_in = 1'b0;
         end
      end else if (cmd.md_step) begin
         md_cnt_in = md_cnt_ff + 6'd1;
         if (md_div_ff) begin
            if (!trial[32]) begin
               md_acc_in = trial[31:0];
               md_q_in   = {md_q_ff[30:0], 1'b1};
            end else begin
               md_acc_in = {md_acc_ff[30:0], md_q_ff[31]};
               md_q_in   = {md_q_ff[30:0], 1'b0};
            end
         end else begin
            // Multiply: scan multiplier from the top, shift-and-add
            md_acc_in = {md_acc_ff[30:0], 1'b0} + (md_q_ff[31] ? md_b_ff : 32'd0);
            md_q_in   = {md_q_ff[30:0], 1'b0};
         end
      end
   end
   assign sts.md_done = md_fix_ff || md_cnt_ff[5];

   always_ff @(posedge clock) begin
      md_acc_ff <= md_acc_in;
      md_q_ff   <= md_q_in;
      md_b_ff   <= md_b_in;
      md_cnt_ff <= md_cnt_in;
      md_neg_ff <= md_neg_in;
      md_fix_ff <= md_fix_in;
      if (cmd.execute) begin
         md_div_ff     <= md_div;
         exe_is_div_ff <= md_div;
      end
   end

   // Commit: final result, register write
   logic [31:0] md_res;
   always_comb begin
      if (md_fix_ff) begin
         md_res = md_q_ff;
      end else if (exe_is_div_ff) begin
         md_res = md_neg_ff ? (32'd0 - md_q_ff) : md_q_ff;
      end else begin
         md_res = md_acc_ff;
      end
      rsp_in = exe_ff;
      if (exe_md_ff) begin
         rsp_in.write_value = md_res;
      end
      if (!rsp_in.write_enable || rsp_in.dest_reg == 5'd0) begin
         rsp_in.write_enable = 1'b0;
         rsp_in.dest_reg     = '0;
         rsp_in.write_value  = '0;
      end
      pc_in = cmd.commit ? rsp_in.next_pc : pc_ff;
   end

   always_comb begin
      if (!clr_cnt_ff[AW]) begin
         wr_en   = cmd.clear_step;
         wr_addr = clr_cnt_ff[AW-1:0];
         wr_data = (clr_cnt_ff[AW-1:0] == AW'(rv32sde_pkg::SP_REG_INDEX))
                   ? rv32sde_pkg::SP_RESET_VALUE : 32'd0;
      end else begin
         wr_en   = cmd.commit && rsp_in.write_enable;
         wr_addr = rsp_in.dest_reg[AW-1:0];
         wr_data = rsp_in.write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         exe_ff    <= exe_in;
         exe_md_ff <= !req_ff.mode && !halt_ff && md_req;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
         pend_ff <= '0;
      end else begin
         pc_ff <= pc_in;
         if (cmd.execute) begin
            halt_ff <= halt_in;
            pend_ff <= pend_in;
         end
      end
   end

   assign rsp_data = rsp_ff;
endmodule

>>> design/rv32sde_control.sv
// Controller of the RV32 subset unit: sequences clear sweep, operand read,
// execute, mul/div iterations, write back and output handshake. Uses rv32sde_pkg.
module rv32sde_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rv32sde_pkg::dp_sts_type sts,
   output rv32sde_pkg::dp_cmd_type cmd
);
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_EXEC   = 6'b001000,
      ST_MULDIV = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      req_fire, rsp_free;

   // Output register may hold a result while the next item is accepted
   assign rsp_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.capture = req_fire;
            if (req_fire) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.execute = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.md_needed) begin
               state_in = ST_MULDIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_MULDIV: begin
            if (sts.md_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.md_step = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

>>> design/rv32_subset_decode_execute_unit.sv
// RV32 subset decode/execute unit. An accepted item passes operand read, execute
// and write back before rsp_valid; mul and div also iterate on the bit-serial unit,
// which divide by zero and the overflow case skip. One item at a time is taken,
// and a waiting result stalls the unit.
// Reset: synchronous; then a sweep loads the register file
// (x2 = 4000, others 0); req_ready rises when the sweep is done.
module rv32_subset_decode_execute_unit #(
   parameter int unsigned NUM_REGS = rv32sde_pkg::NUM_REGS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rv32sde_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rv32sde_pkg::rsp_type rsp_data
);
   rv32sde_pkg::dp_cmd_type cmd;
   rv32sde_pkg::dp_sts_type sts;

   rv32sde_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   rv32sde_datapath #(.NUM_REGS(NUM_REGS)) u_datapath (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_data
   );
endmodule

>>> design/rv32sde_checker.sv
// Port-level checker for the RV32 subset unit, bound to the top level.
// Uses rv32sde_pkg.
module rv32sde_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rv32sde_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_write_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.write_enable && rsp_data.dest_reg == 5'd0))
      else $error("write to x0 reported");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   a_mem_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.mem_op <= rv32sde_pkg::MEM_SW)
      else $error("bad memory op code");
endmodule

bind rv32_subset_decode_execute_unit rv32sde_checker u_rv32sde_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);

>>> sim/rv32_subset_decode_execute_unit_test.sv
// Self-checking testbench for the RV32 subset decode/execute unit.
// Depends on rv32sde_pkg and rv32_subset_decode_execute_unit from design/.
module rv32_subset_decode_execute_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Bit-accurate predictor of the unit, with its own architectural state
   class step_scoreboard;
      logic [31:0] regs [32];
      logic [31:0] pc;
      logic        halt;
      logic [4:0]  load_rd;
      rv32sde_pkg::rsp_type pending_q [$];
      int          errors;

      function new();
         for (int i = 0; i < 32; i++) regs[i] = '0;
         regs[rv32sde_pkg::SP_REG_INDEX] = rv32sde_pkg::SP_RESET_VALUE;
         pc = '0; halt = 1'b0; load_rd = '0; errors = 0;
      endfunction

      function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
         logic [31:0] na, nb, q;
         if (b == 0) return 32'hFFFF_FFFF;
         if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'h8000_0000;
         na = a[31] ? -a : a;
         nb = b[31] ? -b : b;
         q = na / nb;
         return (a[31] ^ b[31]) ? -q : q;
      endfunction

      // Returns 0 for an unsupported function code
      function bit alu(logic [2:0] f3, logic [6:0] f7, logic [31:0] a, logic [31:0] b,
                       bit is_reg, output logic [31:0] res);
         logic [4:0] sh;
         sh = b[4:0];
         res = '0;
         if (is_reg && f7 == rv32sde_pkg::F7_MULDIV) begin
            if (f3 == 0) begin res = a * b; return 1; end
            if (f3 == 4) begin res = sdiv(a, b); return 1; end
            return 0;
         end
         if (is_reg && f7 == rv32sde_pkg::F7_ALT) begin
            if (f3 == 0) begin res = a - b; return 1; end
            if (f3 == 5) begin res = $signed(a) >>> sh; return 1; end
            return 0;
         end
         if (is_reg && f7 != rv32sde_pkg::F7_BASE) return 0;
         case (f3)
            3'd0: res = a + b;
            3'd1: res = a << sh;
            3'd2: res = {31'b0, $signed(a) < $signed(b)};
            3'd3: res = {31'b0, a < b};
            3'd4: res = a ^ b;
            3'd5: begin
               if (f7 == rv32sde_pkg::F7_BASE) res = a >> sh;
               else if (f7 == rv32sde_pkg::F7_ALT) res = $signed(a) >>> sh;
               else return 0;
            end
            3'd6: res = a | b;
            default: res = a & b;
         endcase
         return 1;
      endfunction

      function void note_request(rv32sde_pkg::req_type r);
         rv32sde_pkg::rsp_type e;
         logic [31:0] ir, npc, a, b, immi, val, off;
         logic [6:0] op;
         logic [4:0] rd;
         logic [2:0] f3;
         bit wr, take;
         ir = r.instr_word; npc = pc + 4;
         op = ir[6:0]; rd = ir[11:7]; f3 = ir[14:12];
         a = regs[ir[19:15]]; b = regs[ir[24:20]];
         immi = {{20{ir[31]}}, ir[31:20]};
         e = '0; val = '0; wr = 0;
         if (r.mode) begin
            rd = load_rd; val = r.load_data; wr = 1; load_rd = '0; npc = pc;
         end else if (halt) begin
            npc = pc;
         end else begin
            case (op)
               rv32sde_pkg::OP_HALT: begin halt = 1; npc = pc; end
               rv32sde_pkg::OP_REG, rv32sde_pkg::OP_REGW:
                  if (alu(f3, ir[31:25], a, b, 1, val)) wr = 1;
                  else e.unknown_op = 1;
               rv32sde_pkg::OP_IMM: if (alu(f3, ir[31:25], a, immi, 0, val)) wr = 1;
                  else e.unknown_op = 1;
               rv32sde_pkg::OP_LOAD: begin
                  e.mem_op = (f3 == 0) ? rv32sde_pkg::MEM_LB : rv32sde_pkg::MEM_LW;
                  e.mem_addr = a + immi; load_rd = rd;
               end
               rv32sde_pkg::OP_STORE: begin
                  e.mem_op = (f3 == 0) ? rv32sde_pkg::MEM_SB : rv32sde_pkg::MEM_SW;
                  e.mem_addr = a + {{20{ir[31]}}, ir[31:25], ir[11:7]};
                  e.store_value = b;
               end
               rv32sde_pkg::OP_BRANCH: begin
                  off = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
                  take = 0;
                  case (f3)
                     3'd0: take = a == b;
                     3'd1: take = a != b;
                     3'd4: take = $signed(a) < $signed(b);
                     3'd5: take = !($signed(a) < $signed(b));
                     3'd6: take = a < b;
                     3'd7: take = a >= b;
                     default: e.unknown_op = 1;
                  endcase
                  if (take) npc = pc + off;
               end
               rv32sde_pkg::OP_JALR: begin
                  npc = (a + immi) & ~32'd1; val = pc + 4; wr = 1;
               end
               rv32sde_pkg::OP_JAL: begin
                  off = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
                  val = pc + 4; npc = pc + off; wr = 1;
               end
               rv32sde_pkg::OP_LUI: begin val = {ir[31:12], 12'b0}; wr = 1; end
               rv32sde_pkg::OP_LA: begin val = {{12{ir[31]}}, ir[31:12]}; wr = 1; end
               default: e.unknown_op = 1;
            endcase
         end
         if (wr && rd != 0) begin
            regs[rd] = val;
            e.dest_reg = rd; e.write_value = val; e.write_enable = 1;
         end
         pc = npc;
         e.next_pc = npc;
         e.halted = halt;
         pending_q.insert(pending_q.size(), e);
      endfunction

      function void check_result(rv32sde_pkg::rsp_type got);
         rv32sde_pkg::rsp_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got !== e) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
            if (got.next_pc !== e.next_pc)
               $display("  next_pc exp %h act %h", e.next_pc, got.next_pc);
            if (got.write_value !== e.write_value)
               $display("  write_value exp %h act %h", e.write_value, got.write_value);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   rv32sde_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rv32sde_pkg::rsp_type rsp_data;

   step_scoreboard sb = new();
   bit  calm = 0;         // stretch with no idling
   int  idle_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   always #1 clock = ~clock;

   rv32_subset_decode_execute_unit dut (.*);

   // Observe transfers at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** rv32_subset_decode_execute_unit: FAILED **");
            $finish;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

   function logic [31:0] rtype(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                               logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   // Drive one request at the falling edge and hold it until the transfer;
   // req_ready only moves at the rising edge, so its value here is the one
   // seen at the next rising edge
   task send(bit mode, logic [31:0] word, logic [31:0] data);
      bit taken;
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{mode: mode, instr_word: word, load_data: data};
      taken = 1'b0;
      while (!taken) begin
         taken = req_ready;
         @(posedge clock);
         @(negedge clock);
      end
   endtask

   task send_instr(logic [31:0] word);
      send(1'b0, word, $urandom);
      if (word[6:0] == rv32sde_pkg::OP_LOAD && !sb.halt) send(1'b1, $urandom, $urandom);
   endtask

   // Random instruction, mostly from the supported opcodes; halt is never generated
   function logic [31:0] random_instr();
      logic [6:0] ops [11] = '{rv32sde_pkg::OP_REG, rv32sde_pkg::OP_REGW,
                                rv32sde_pkg::OP_IMM, rv32sde_pkg::OP_LOAD,
                                rv32sde_pkg::OP_STORE, rv32sde_pkg::OP_BRANCH,
                                rv32sde_pkg::OP_JALR, rv32sde_pkg::OP_JAL,
                                rv32sde_pkg::OP_LUI, rv32sde_pkg::OP_LA,
                                rv32sde_pkg::OP_REG};
      logic [31:0] w;
      logic [6:0] f7s [3] = '{rv32sde_pkg::F7_BASE, rv32sde_pkg::F7_MULDIV,
                              rv32sde_pkg::F7_ALT};
      w = $urandom;
      if ($urandom_range(9) < 8) begin
         w[6:0] = ops[$urandom_range(10)];
         if (w[6:0] == rv32sde_pkg::OP_REG || w[6:0] == rv32sde_pkg::OP_REGW)
            w[31:25] = f7s[$urandom_range(2)];
         if (w[6:0] == rv32sde_pkg::OP_IMM && w[14:12] == 3'd5)
            w[31:25] = f7s[$urandom_range(2)];
      end else if (w[6:0] == rv32sde_pkg::OP_HALT) w[6:0] = 7'd15;
      return w;
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed part
      send_instr(rtype(rv32sde_pkg::F7_BASE, 5'd0, 5'd0, 3'd0, 5'd0, rv32sde_pkg::OP_LA)
                 | 32'hFFFF_F000);                                         // la to x0
      send_instr({20'h80000, 5'd5, rv32sde_pkg::OP_LA});
      send_instr({20'h7FFFF, 5'd6, rv32sde_pkg::OP_LUI});
      send_instr({12'hFFF, 5'd0, 3'd0, 5'd7, rv32sde_pkg::OP_IMM});
      send_instr(rtype(rv32sde_pkg::F7_MULDIV, 5'd7, 5'd5, 3'd4, 5'd8,
                       rv32sde_pkg::OP_REG));                              // div
      send_instr(rtype(rv32sde_pkg::F7_MULDIV, 5'd0, 5'd5, 3'd4, 5'd9,
                       rv32sde_pkg::OP_REG));                              // div by zero
      send_instr({20'h80000, 5'd10, rv32sde_pkg::OP_LUI});
      send_instr(rtype(rv32sde_pkg::F7_MULDIV, 5'd7, 5'd10, 3'd4, 5'd11,
                       rv32sde_pkg::OP_REG));                              // overflow
      send_instr(rtype(rv32sde_pkg::F7_MULDIV, 5'd6, 5'd6, 3'd0, 5'd12,
                       rv32sde_pkg::OP_REGW));                             // mul
      send_instr(rtype(rv32sde_pkg::F7_BASE, 5'd7, 5'd10, 3'd2, 5'd13,
                       rv32sde_pkg::OP_REG));                              // slt
      send_instr(rtype(rv32sde_pkg::F7_BASE, 5'd7, 5'd10, 3'd3, 5'd14,
                       rv32sde_pkg::OP_REG));                              // sltu
      send_instr(rtype(rv32sde_pkg::F7_ALT, 5'd7, 5'd10, 3'd5, 5'd15,
                       rv32sde_pkg::OP_REG));                              // sra
      send_instr(rtype(rv32sde_pkg::F7_BASE, 5'd7, 5'd10, 3'd5, 5'd16,
                       rv32sde_pkg::OP_REG));                              // srl
      send_instr(rtype(7'd5, 5'd7, 5'd10, 3'd5, 5'd16, rv32sde_pkg::OP_REG)); // bad funct7
      send_instr({7'h7F, 5'd7, 5'd2, 3'd2, 5'h1F, rv32sde_pkg::OP_STORE});
      send_instr({12'h800, 5'd2, 3'd0, 5'd17, rv32sde_pkg::OP_LOAD});
      send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);                          // nothing pending
      send_instr({7'h40, 5'd7, 5'd10, 3'd2, 5'h10, rv32sde_pkg::OP_BRANCH}); // bad branch
      send_instr({7'h7F, 5'd7, 5'd10, 3'd4, 5'h1F, rv32sde_pkg::OP_BRANCH});
      send_instr({12'hFFF, 5'd2, 3'd0, 5'd18, rv32sde_pkg::OP_JALR});
      send_instr({20'hFFFFF, 5'd1, rv32sde_pkg::OP_JAL});
      send_instr(32'd27);
      // Random part, with a calm stretch in the middle
      for (int i = 0; i < 700; i++) begin
         calm = (i >= 300 && i < 400);
         send_instr(random_instr());
      end
      calm = 0;
      // Halt, then show instructions are ignored; load data is still taken, nothing pending
      send_instr({25'd0, rv32sde_pkg::OP_HALT});
      for (int i = 0; i < 25; i++) send(i[0], $urandom, $urandom);
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("** rv32_subset_decode_execute_unit: PASSED **");
      else
         $display("** rv32_subset_decode_execute_unit: FAILED **");
      $finish;
   end
endmodule
